@@ hdl/box_muller_normal_sample_macros.svh @@
// ----------------------------------------------------------------------------
// Box-Muller sampler assertion macros
// Shared helpers for the concurrent checks of the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_MULLER_NORMAL_SAMPLE_MACROS_SVH
`define BOX_MULLER_NORMAL_SAMPLE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define BMS_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define BMS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bms_pkg.sv @@
// ----------------------------------------------------------------------------
// Box-Muller sampler package
// Field widths, fixed-point constants and Taylor tables of the sampler.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int UNIFORM_W  = 31;
	localparam int SAMPLE_W   = 32;
	localparam int VAR_W      = 32;
	localparam int RANGE_W    = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PHASE_W    = 32;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int UNIFORM_BITS_DEF = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_MEAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd2;

	localparam logic [VAR_W-1:0]   VAR_RESET   = 32'd65536;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 31'd2147483646;

	// log2 values carry a 5-bit exponent and LOG_FB fraction bits.
	localparam int LOG_FB  = 28;
	localparam int LOG_E_W = 5;
	localparam int LOG_W   = LOG_E_W + LOG_FB;
	localparam int LOG_LAT = 2 + LOG_FB;
	localparam int R2_W    = 34;

	localparam int TRIG_FB = 30;
	localparam logic [28:0] LN2X2_Q28   = 29'd372130559;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;

	localparam int TAYLOR_TERMS = 8;
	localparam int RECIP_SH     = 36;
	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SH;

	// Divisors a*(a+1) of each series term; row 0 is cosine, row 1 is sine.
	localparam logic [8:0] TAYLOR_DIV [2][TAYLOR_TERMS] = '{
		'{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240},
		'{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272}
	};

	// floor(2^36 / divisor), used for the reciprocal multiply.
	localparam logic [35:0] TAYLOR_RECIP [2][TAYLOR_TERMS] = '{
		'{36'(RECIP_ONE / 64'd2),   36'(RECIP_ONE / 64'd12),
		  36'(RECIP_ONE / 64'd30),  36'(RECIP_ONE / 64'd56),
		  36'(RECIP_ONE / 64'd90),  36'(RECIP_ONE / 64'd132),
		  36'(RECIP_ONE / 64'd182), 36'(RECIP_ONE / 64'd240)},
		'{36'(RECIP_ONE / 64'd6),   36'(RECIP_ONE / 64'd20),
		  36'(RECIP_ONE / 64'd42),  36'(RECIP_ONE / 64'd72),
		  36'(RECIP_ONE / 64'd110), 36'(RECIP_ONE / 64'd156),
		  36'(RECIP_ONE / 64'd210), 36'(RECIP_ONE / 64'd272)}
	};

endpackage

@@ hdl/bms_if.sv @@
// ----------------------------------------------------------------------------
// Box-Muller sampler channels
// Draw, sample and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bms_draw_if import bms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [UNIFORM_W-1:0] uniform_radius;
	logic [UNIFORM_W-1:0] uniform_angle;
	logic                 last_draw;

	modport source(output valid, uniform_radius, uniform_angle, last_draw, input ready);
	modport sink(input valid, uniform_radius, uniform_angle, last_draw, output ready);
endinterface

interface bms_sample_if import bms_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] normal_sample;
	logic                       saturated;
	logic                       last_sample;

	modport source(output valid, normal_sample, saturated, last_sample, input ready);
	modport sink(input valid, normal_sample, saturated, last_sample, output ready);
endinterface

interface bms_cfg_if import bms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/bms_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module bms_isqrt #(
	parameter int IN_W = 62
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   x,
	output logic [IN_W/2-1:0] root
);
	localparam int STEPS = IN_W / 2;

	logic [IN_W-1:0] v_s [1:STEPS];
	logic [IN_W-1:0] r_s [1:STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * j);
		logic [IN_W-1:0] v_in;
		logic [IN_W-1:0] r_in;
		logic [IN_W-1:0] trial;
		logic            ge;

		if (j == 0) begin : g_first
			assign v_in = x;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[j];
			assign r_in = r_s[j];
		end

		assign trial = r_in + BIT;
		assign ge    = v_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[j+1] <= ge ? v_in - trial : v_in;
				r_s[j+1] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
			end
		end
	end

	assign root = r_s[STEPS][STEPS-1:0];
endmodule

@@ hdl/bms_log2.sv @@
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// Integer part from the leading one, fraction bits by repeated squaring.
// ----------------------------------------------------------------------------
module bms_log2 import bms_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [UNIFORM_W-1:0] n,
	output logic [LOG_W-1:0]     lg
);
	logic [UNIFORM_W-1:0] n_s1;
	logic [LOG_E_W-1:0]   e_s1;
	logic [LOG_FB:0]      m_s2;
	logic [LOG_E_W-1:0]   e_s2;
	logic [LOG_E_W-1:0]   lead;
	logic [UNIFORM_W+LOG_FB-1:0] nw;

	logic [LOG_FB:0]        m_s [1:LOG_FB];
	logic [LOG_E_W-1:0]     e_s [1:LOG_FB];
	logic [LOG_FB-1:0]      f_s [1:LOG_FB];

	always_comb begin
		lead = '0;
		for (int i = 1; i < UNIFORM_W; i++) begin
			if (n[i]) begin
				lead = LOG_E_W'(i);
			end
		end
	end

	// Placing n at LOG_FB fraction bits and shifting right by the exponent
	// normalizes the mantissa of any nonzero n into [1, 2) for either shift direction.
	assign nw = {n_s1, {LOG_FB{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= n;
			e_s1 <= lead;
			m_s2 <= (LOG_FB + 1)'(nw >> e_s1);
			e_s2 <= e_s1;
		end
	end

	for (genvar j = 0; j < LOG_FB; j++) begin : g_sq
		logic [LOG_FB:0]       m_in;
		logic [LOG_E_W-1:0]    e_in;
		logic [LOG_FB-1:0]     f_in;
		logic [2*LOG_FB+1:0]   sq;
		logic [LOG_FB+1:0]     s;
		logic [LOG_FB-1:0]     f_nx;

		if (j == 0) begin : g_first
			assign m_in = m_s2;
			assign e_in = e_s2;
			assign f_in = '0;
		end else begin : g_next
			assign m_in = m_s[j];
			assign e_in = e_s[j];
			assign f_in = f_s[j];
		end

		assign sq = (2 * LOG_FB + 2)'(m_in) * (2 * LOG_FB + 2)'(m_in);
		assign s  = sq[2*LOG_FB+1:LOG_FB];

		always_comb begin
			f_nx = f_in;
			f_nx[LOG_FB-1-j] = s[LOG_FB+1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j+1] <= s[LOG_FB+1] ? s[LOG_FB+1:1] : s[LOG_FB:0];
				e_s[j+1] <= e_in;
				f_s[j+1] <= f_nx;
			end
		end
	end

	assign lg = {e_s[LOG_FB], f_s[LOG_FB]};
endmodule

@@ hdl/box_muller_normal_sample.sv @@
// ----------------------------------------------------------------------------
// Box-Muller normal sampler
// Cosine branch of the Box-Muller transform in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: a pair of uniform draws enters on the draw channel and one Gaussian
// sample leaves on the sample channel, mean + sd * sqrt(-2 ln u1) * cos(2 pi u2),
// with FRAC_BITS fraction bits. The last_draw marker rides along unchanged.
// The cfg channel writes mean_offset (index 0), target_variance (index 1) and
// range_max (index 2); it is always ready and ignores other indexes. Write it
// only while no transaction is in flight.
// The path from draw to sample runs through the 63-step phase divider and the
// eight-term Taylor series behind it. A new draw is taken every cycle while the
// output is not stalled, so the sustained rate is one sample per cycle.
// The whole pipeline advances together: while a sample waits at the output and
// the receiver holds ready low, draw ready drops and every stage holds.
// Reset clears all valid bits and loads the configuration reset values; draw
// ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
`include "box_muller_normal_sample_macros.svh"

module box_muller_normal_sample import bms_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bms_draw_if.sink     draw,
	bms_sample_if.source sample,
	bms_cfg_if.sink      cfg
);
	localparam int UW        = (UNIFORM_BITS < UNIFORM_W) ? UNIFORM_BITS : UNIFORM_W;
	localparam logic [UNIFORM_W-1:0] UMASK = UNIFORM_W'((64'd1 << UW) - 64'd1);
	localparam int DIV_STEPS = UNIFORM_W + PHASE_W;
	localparam int ANG_LAT   = DIV_STEPS + 2 + 3 * TAYLOR_TERMS + 1;
	localparam int RAD_IN_W  = R2_W + LOG_FB;
	localparam int RAD_LAT   = LOG_LAT + 2 + RAD_IN_W / 2;
	localparam int RAD_DLY   = ANG_LAT - RAD_LAT;
	localparam int OUT_LAT   = ANG_LAT + 3;
	localparam int SD_IN_W   = VAR_W + FRAC_BITS;
	localparam int SD_W      = SD_IN_W + (SD_IN_W % 2);
	localparam int SD_R_W    = SD_W / 2;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		logic valid;
		logic last;
		logic zero;
		logic above;
	} ctl_t;

	typedef struct packed {
		logic [1:0]         quad;
		logic [PHASE_W-1:0] t2;
		logic signed [35:0] acc;
	} trig_t;

	logic en;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [VAR_W-1:0]           var_q;
	logic [RANGE_W-1:0]         rm_q;
	logic [UNIFORM_W-1:0]       u1;
	logic [UNIFORM_W-1:0]       u2;
	ctl_t                       ctl_s [1:OUT_LAT];

	assign en         = !ctl_s[OUT_LAT].valid || sample.ready;
	assign draw.ready = en;
	assign cfg.ready  = 1'b1;
	assign u1         = draw.uniform_radius & UMASK;
	assign u2         = draw.uniform_angle & UMASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			var_q  <= VAR_RESET;
			rm_q   <= RANGE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MEAN:  mean_q <= cfg.data;
				CFG_VAR:   var_q  <= cfg.data;
				CFG_RANGE: rm_q   <= cfg.data[RANGE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= OUT_LAT; i++) begin
				ctl_s[i] <= '0;
			end
		end else if (en) begin
			ctl_s[1] <= '{valid: draw.valid, last: draw.last_draw,
			              zero: u1 == '0, above: u1 > rm_q};
			for (int i = 2; i <= OUT_LAT; i++) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	// Phase: restoring division of u2 * 2^32 by range_max. The low 32
	// quotient bits equal ((u2 mod range_max) << 32) / range_max.
	logic [UNIFORM_W-1:0] rem_s  [1:DIV_STEPS];
	logic [DIV_STEPS-1:0] work_s [1:DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [UNIFORM_W-1:0] rem_in;
		logic [DIV_STEPS-1:0] work_in;
		logic [UNIFORM_W:0]   cur;
		logic [UNIFORM_W:0]   diff;
		logic                 qb;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign work_in = {u2, {PHASE_W{1'b0}}};
		end else begin : g_next
			assign rem_in  = rem_s[j];
			assign work_in = work_s[j];
		end

		assign cur  = {rem_in, work_in[DIV_STEPS-1]};
		assign diff = cur - {1'b0, rm_q};
		assign qb   = cur >= {1'b0, rm_q};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= qb ? diff[UNIFORM_W-1:0] : cur[UNIFORM_W-1:0];
				work_s[j+1] <= {work_in[DIV_STEPS-2:0], qb};
			end
		end
	end

	logic [PHASE_W-1:0]      phase;
	logic [2*TRIG_FB:0]      thp;
	logic [1:0]              quad_s64;
	logic [TRIG_FB:0]        th_s64;
	logic [2*TRIG_FB+1:0]    t2p;
	logic [33:0]             t_s65;
	trig_t                   car_s65;

	assign phase = (rm_q == '0) ? '0 : work_s[DIV_STEPS][PHASE_W-1:0];
	assign thp   = (2 * TRIG_FB + 1)'(phase[TRIG_FB-1:0]) * (2 * TRIG_FB + 1)'(HALF_PI_Q30);
	assign t2p   = (2 * TRIG_FB + 2)'(th_s64) * (2 * TRIG_FB + 2)'(th_s64);

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s64     <= phase[PHASE_W-1:PHASE_W-2];
			th_s64       <= thp[2*TRIG_FB:TRIG_FB];
			t_s65        <= quad_s64[0] ? 34'(th_s64) : 34'(ONE_Q30);
			car_s65.quad <= quad_s64;
			car_s65.t2   <= t2p[2*TRIG_FB+1:TRIG_FB];
			car_s65.acc  <= quad_s64[0] ? 36'(th_s64) : 36'(ONE_Q30);
		end
	end

	// Taylor series: per term, one stage multiplies by theta squared, one by
	// the divisor's reciprocal, and one corrects the quotient and accumulates.
	logic [33:0] x_sa    [TAYLOR_TERMS];
	trig_t       car_sa  [TAYLOR_TERMS];
	logic [33:0] prod_sb [TAYLOR_TERMS];
	logic [33:0] x_sb    [TAYLOR_TERMS];
	trig_t       car_sb  [TAYLOR_TERMS];
	logic [33:0] t_sc    [TAYLOR_TERMS];
	trig_t       car_sc  [TAYLOR_TERMS];

	for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
		logic [33:0] t_in;
		trig_t       car_in;
		logic [65:0] tp;
		logic [69:0] rp;
		logic [8:0]  dv;
		logic [42:0] qd;
		logic [33:0] rr;
		logic [33:0] q;

		if (k == 0) begin : g_first
			assign t_in   = t_s65;
			assign car_in = car_s65;
		end else begin : g_next
			assign t_in   = t_sc[k-1];
			assign car_in = car_sc[k-1];
		end

		assign tp = 66'(t_in) * 66'(car_in.t2);
		assign rp = 70'(x_sa[k]) * 70'(TAYLOR_RECIP[car_sa[k].quad[0]][k]);
		assign dv = TAYLOR_DIV[car_sb[k].quad[0]][k];
		assign qd = 43'(prod_sb[k]) * 43'(dv);
		assign rr = x_sb[k] - qd[33:0];
		assign q  = (rr >= 34'(dv)) ? prod_sb[k] + 34'd1 : prod_sb[k];

		always_ff @(posedge clk) begin
			if (en) begin
				x_sa[k]    <= tp[63:TRIG_FB];
				car_sa[k]  <= car_in;
				prod_sb[k] <= rp[69:RECIP_SH];
				x_sb[k]    <= x_sa[k];
				car_sb[k]  <= car_sa[k];
				t_sc[k]    <= q;
				car_sc[k].quad <= car_sb[k].quad;
				car_sc[k].t2   <= car_sb[k].t2;
				if ((k % 2) == 0) begin
					car_sc[k].acc <= car_sb[k].acc - $signed(36'(q));
				end else begin
					car_sc[k].acc <= car_sb[k].acc + $signed(36'(q));
				end
			end
		end
	end

	logic signed [35:0] acc_end;
	logic [1:0]         quad_end;
	logic [TRIG_FB:0]   c_cl;
	logic [TRIG_FB:0]   c_s90;
	logic               neg_s90;

	assign acc_end  = car_sc[TAYLOR_TERMS-1].acc;
	assign quad_end = car_sc[TAYLOR_TERMS-1].quad;

	always_comb begin
		if (acc_end < 0) begin
			c_cl = '0;
		end else if (acc_end > $signed(36'(ONE_Q30))) begin
			c_cl = ONE_Q30;
		end else begin
			c_cl = acc_end[TRIG_FB:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s90   <= c_cl;
			neg_s90 <= (quad_end == 2'd1 || quad_end == 2'd2) && c_cl != '0;
		end
	end

	// Radius: sqrt(-2 ln(u1 / range_max)) from the difference of two logs.
	logic [LOG_W-1:0]         lb;
	logic [LOG_W-1:0]         la;
	logic [LOG_W-1:0]         d_s31;
	logic [R2_W-1:0]          r2_s32;
	logic [LOG_W+28:0]        r2p;
	logic [RAD_IN_W/2-1:0]    rad;
	logic [RAD_IN_W/2-1:0]    rad_s [1:RAD_DLY];
	logic [SD_R_W-1:0]        sd;

	bms_log2 u_log_draw (.clk(clk), .en(en), .n(u1), .lg(lb));
	bms_log2 u_log_range (.clk(clk), .en(en), .n(rm_q), .lg(la));

	assign r2p = (LOG_W + 29)'(d_s31) * (LOG_W + 29)'(LN2X2_Q28);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s31  <= (la > lb) ? la - lb : '0;
			r2_s32 <= r2p[LOG_FB+R2_W-1:LOG_FB];
		end
	end

	bms_isqrt #(.IN_W(RAD_IN_W)) u_rad_sqrt (
		.clk(clk), .en(en), .x({r2_s32, {LOG_FB{1'b0}}}), .root(rad)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[1] <= rad;
			for (int i = 2; i <= RAD_DLY; i++) begin
				rad_s[i] <= rad_s[i-1];
			end
		end
	end

	// The variance must stay static while samples are in flight, which the block does not
	// enforce, so its root settles long before any sample reaches the scaling stage.
	bms_isqrt #(.IN_W(SD_W)) u_sd_sqrt (
		.clk(clk), .en(en), .x(SD_W'({var_q, {FRAC_BITS{1'b0}}})), .root(sd)
	);

	logic [2*TRIG_FB+1:0]        magp;
	logic [TRIG_FB:0]            mag_s91;
	logic                        neg_s91;
	logic [TRIG_FB+SD_R_W:0]     valp;
	logic [TRIG_FB:0]            val_s92;
	logic                        neg_s92;
	logic signed [SAMPLE_W+1:0]  sm;
	logic signed [SAMPLE_W-1:0]  res_nx;
	logic                        sat_nx;
	logic signed [SAMPLE_W-1:0]  normal_s93;
	logic                        sat_s93;

	assign magp = (2 * TRIG_FB + 2)'(rad_s[RAD_DLY]) * (2 * TRIG_FB + 2)'(c_s90);
	assign valp = (TRIG_FB + SD_R_W + 1)'(mag_s91) * (TRIG_FB + SD_R_W + 1)'(sd);

	always_comb begin
		if (neg_s92) begin
			sm = (SAMPLE_W + 2)'(mean_q) - $signed((SAMPLE_W + 2)'(val_s92));
		end else begin
			sm = (SAMPLE_W + 2)'(mean_q) + $signed((SAMPLE_W + 2)'(val_s92));
		end
		priority if (ctl_s[OUT_LAT-1].zero) begin
			res_nx = neg_s92 ? S_MIN : S_MAX;
			sat_nx = 1'b1;
		end else if (ctl_s[OUT_LAT-1].above) begin
			res_nx = mean_q;
			sat_nx = 1'b1;
		end else if (sm > $signed((SAMPLE_W + 2)'(S_MAX))) begin
			res_nx = S_MAX;
			sat_nx = 1'b1;
		end else if (sm < $signed((SAMPLE_W + 2)'(S_MIN))) begin
			res_nx = S_MIN;
			sat_nx = 1'b1;
		end else begin
			res_nx = sm[SAMPLE_W-1:0];
			sat_nx = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s91    <= magp[2*TRIG_FB:TRIG_FB];
			neg_s91    <= neg_s90;
			val_s92    <= (TRIG_FB + 1)'(valp >> LOG_FB);
			neg_s92    <= neg_s91;
			normal_s93 <= res_nx;
			sat_s93    <= sat_nx;
		end
	end

	assign sample.valid         = ctl_s[OUT_LAT].valid;
	assign sample.normal_sample = normal_s93;
	assign sample.saturated     = sat_s93;
	assign sample.last_sample   = ctl_s[OUT_LAT].last;

	`BMS_CHECK_NEXT(a_draw_enters, draw.valid && draw.ready, ctl_s[1].valid, "accepted draw lost at entry")
	`BMS_CHECK_IMP(a_rem_below_range, ctl_s[DIV_STEPS].valid && rm_q != '0, rem_s[DIV_STEPS] < rm_q, "phase remainder not below range_max")
	`BMS_CHECK_IMP(a_cos_bounded, ctl_s[ANG_LAT].valid, c_s90 <= ONE_Q30, "cosine term above one")
	`BMS_CHECK_IMP(a_zero_draw_clamps, sample.valid && ctl_s[OUT_LAT].zero, sample.saturated && (sample.normal_sample == S_MAX || sample.normal_sample == S_MIN), "zero draw not clamped")
	`BMS_CHECK_IMP(a_above_gives_mean, sample.valid && ctl_s[OUT_LAT].above && !ctl_s[OUT_LAT].zero, sample.saturated && sample.normal_sample == mean_q, "out-of-range draw not replaced by mean")

endmodule
